// File: src/tcphs_pkg.sv
package tcphs_pkg;

    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_CLIENT_ADDR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_ADDR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIENT_PORT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_PORT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_SEQ = 3'd4;

    localparam logic [16:0] MAX_PAYLOAD = 17'd65495;

    localparam logic [7:0]  IP_VER_IHL  = 8'h45;
    localparam logic [7:0]  IP_TTL      = 8'd64;
    localparam logic [7:0]  IP_PROTO    = 8'd6;
    localparam logic [16:0] IP_HDR_LEN  = 17'd40;
    localparam logic [16:0] TCP_HDR_LEN = 17'd20;
    localparam logic [3:0]  TCP_DOFF    = 4'd5;
    localparam logic [11:0] TCP_FLAGS   = 12'h010;
    localparam logic [15:0] TCP_WINDOW  = 16'hFFFF;

    localparam logic [3:0] W_VER_LEN   = 4'd0;
    localparam logic [3:0] W_IDENT     = 4'd1;
    localparam logic [3:0] W_TTL_CSUM  = 4'd2;
    localparam logic [3:0] W_SRC_ADDR  = 4'd3;
    localparam logic [3:0] W_DST_ADDR  = 4'd4;
    localparam logic [3:0] W_PORTS     = 4'd5;
    localparam logic [3:0] W_SEQ       = 4'd6;
    localparam logic [3:0] W_ACK       = 4'd7;
    localparam logic [3:0] W_FLAGS_WIN = 4'd8;
    localparam logic [3:0] W_CSUM_URG  = 4'd9;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       byte_valid;
        logic       end_of_segment;
        logic       from_target;
    } in_beat_t;

    typedef struct packed {
        logic [31:0] header_word;
        logic [3:0]  word_index;
        logic        last_word;
        logic        oversize;
    } out_beat_t;

    typedef struct packed {
        logic [31:0] src;
        logic [31:0] dst;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [31:0] seq;
        logic [31:0] ack;
        logic [15:0] ident;
        logic [16:0] count;
        logic [15:0] sum;
        logic        too_long;
    } hdr_snap_t;

    // ones' complement fold with end-around carry
    function automatic logic [15:0] fold_sum(input logic [19:0] s);
        logic [16:0] t;
        t = {1'b0, s[15:0]} + {13'b0, s[19:16]};
        t = {1'b0, t[15:0]} + {16'b0, t[16]};
        return t[15:0];
    endfunction

endpackage

// File: src/tcp_ipv4_header_synth.sv
// IPv4 + TCP header generator for a byte-stream payload.
// Input channel (s_valid/s_ready/s_data): one payload beat per cycle while
// s_ready is high, with byte_valid, end_of_segment and the sender side.
// Bytes sum on arrival; an end beat snapshots the segment for the emitter.
// Output channel (m_valid/m_ready/m_data): ten 32-bit header words per
// segment, IP header first, word_index 0..9, last_word on word 9.
// Header path: end beat to input register, snapshot to header register,
// first word to output register; then one per cycle while m_ready is high.
// Throughput: one input beat per cycle, set by the input register; payload
// beats of the next segment are taken while a header is still going out.
// An end beat waits in the input register until the header emitter is free,
// so the next end beat holds s_ready low while a header is going out.
// A stalled receiver holds the output register, then the emitter, then the
// input register; nothing is dropped.
// Configuration (cfg_we/cfg_index/cfg_wdata): user writes while idle;
// the block does not enforce it; initial_seq reloads both sequences.
// Reset (aresetn low, synchronous): state registers clear to zero, the
// target sequence to all ones; data is not reset; both channels go empty.
module tcp_ipv4_header_synth
    import tcphs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_beat_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_beat_t             m_data
);

    logic      snap_valid;
    logic      snap_ready;
    hdr_snap_t snap;

    tcphs_accum u_accum (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready),
        .snap       (snap)
    );

    tcphs_emit u_emit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready),
        .snap       (snap),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

// File: src/tcphs_accum.sv
module tcphs_accum
    import tcphs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_beat_t              s_data,
    output logic                  snap_valid,
    input  logic                  snap_ready,
    output hdr_snap_t             snap
);

    logic        in_valid_reg;
    in_beat_t    in_data_reg;
    logic [31:0] client_addr_reg, target_addr_reg;
    logic [15:0] client_port_reg, target_port_reg;
    logic [31:0] client_seq_reg, target_seq_reg;
    logic [15:0] ident_reg;
    logic [15:0] sum_reg, sum_next;
    logic [16:0] count_reg, count_next;
    logic        too_long_reg, too_long_next;
    logic [15:0] byte_word;
    logic        is_end;
    logic        consume;

    assign is_end     = in_data_reg.end_of_segment;
    assign consume    = in_valid_reg && (!is_end || snap_ready);
    assign s_ready    = !in_valid_reg || consume;
    assign snap_valid = in_valid_reg && is_end;

    // even byte positions are the high half of a 16-bit word
    assign byte_word = count_reg[0] ? {8'h00, in_data_reg.payload_byte}
                                    : {in_data_reg.payload_byte, 8'h00};

    always_comb begin
        sum_next      = sum_reg;
        count_next    = count_reg;
        too_long_next = too_long_reg;
        if (in_data_reg.byte_valid) begin
            sum_next   = fold_sum({4'b0, sum_reg} + {4'b0, byte_word});
            count_next = count_reg + 17'd1;
            if (count_reg == MAX_PAYLOAD) begin
                too_long_next = 1'b1;
            end
        end
    end

    always_comb begin
        snap.count    = count_next;
        snap.sum      = sum_next;
        snap.too_long = too_long_next;
        snap.ident    = ident_reg;
        if (in_data_reg.from_target) begin
            snap.src   = target_addr_reg;
            snap.dst   = client_addr_reg;
            snap.sport = target_port_reg;
            snap.dport = client_port_reg;
            snap.seq   = target_seq_reg;
            snap.ack   = client_seq_reg;
        end else begin
            snap.src   = client_addr_reg;
            snap.dst   = target_addr_reg;
            snap.sport = client_port_reg;
            snap.dport = target_port_reg;
            snap.seq   = client_seq_reg;
            snap.ack   = target_seq_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            client_addr_reg <= '0;
            target_addr_reg <= '0;
            client_port_reg <= '0;
            target_port_reg <= '0;
            client_seq_reg  <= '0;
            target_seq_reg  <= '1;
            ident_reg       <= '0;
            sum_reg         <= '0;
            count_reg       <= '0;
            too_long_reg    <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (consume) begin
                in_valid_reg <= 1'b0;
            end

            if (consume) begin
                if (is_end) begin
                    // advance the sender, clear the segment totals
                    if (in_data_reg.from_target) begin
                        target_seq_reg <= target_seq_reg + {15'b0, count_next};
                    end else begin
                        client_seq_reg <= client_seq_reg + {15'b0, count_next};
                    end
                    ident_reg    <= ident_reg + 16'd1;
                    sum_reg      <= '0;
                    count_reg    <= '0;
                    too_long_reg <= 1'b0;
                end else begin
                    sum_reg      <= sum_next;
                    count_reg    <= count_next;
                    too_long_reg <= too_long_next;
                end
            end

            if (cfg_we) begin
                case (cfg_index)
                    CFG_CLIENT_ADDR: client_addr_reg <= cfg_wdata;
                    CFG_TARGET_ADDR: target_addr_reg <= cfg_wdata;
                    CFG_CLIENT_PORT: client_port_reg <= cfg_wdata[15:0];
                    CFG_TARGET_PORT: target_port_reg <= cfg_wdata[15:0];
                    CFG_INITIAL_SEQ: begin
                        client_seq_reg <= cfg_wdata;
                        target_seq_reg <= ~cfg_wdata;
                    end
                    default: ;
                endcase
            end
        end
    end

endmodule

// File: src/tcphs_emit.sv
module tcphs_emit
    import tcphs_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      snap_valid,
    output logic      snap_ready,
    input  hdr_snap_t snap,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    logic        hdr_valid_reg;
    hdr_snap_t   hdr_reg;
    logic [3:0]  idx_reg;
    logic        m_valid_reg;
    out_beat_t   m_data_reg;
    logic        load;
    logic        pop;
    logic        last;
    logic [15:0] tot_len, tcp_len;
    logic [16:0] tot_len_w, tcp_len_w;
    logic [15:0] ip_csum, tcp_csum;
    logic [19:0] ip_acc, tcp_acc;
    logic [31:0] word;

    assign load       = !m_valid_reg || m_ready;
    assign pop        = hdr_valid_reg && load;
    assign last       = (idx_reg == W_CSUM_URG);
    assign snap_ready = !hdr_valid_reg || (pop && last);

    assign tot_len_w = hdr_reg.count + IP_HDR_LEN;
    assign tcp_len_w = hdr_reg.count + TCP_HDR_LEN;
    assign tot_len   = tot_len_w[15:0];
    assign tcp_len   = tcp_len_w[15:0];

    always_comb begin
        ip_acc = {4'b0, IP_VER_IHL, 8'h00} + {4'b0, tot_len} + {4'b0, hdr_reg.ident}
               + {4'b0, IP_TTL, IP_PROTO}
               + {4'b0, hdr_reg.src[31:16]} + {4'b0, hdr_reg.src[15:0]}
               + {4'b0, hdr_reg.dst[31:16]} + {4'b0, hdr_reg.dst[15:0]};
        ip_csum = ~fold_sum(ip_acc);

        // pseudo-header, TCP header and padded payload sum
        tcp_acc = {4'b0, hdr_reg.sum} + {4'b0, hdr_reg.sport} + {4'b0, hdr_reg.dport}
                + {4'b0, hdr_reg.seq[31:16]} + {4'b0, hdr_reg.seq[15:0]}
                + {4'b0, hdr_reg.ack[31:16]} + {4'b0, hdr_reg.ack[15:0]}
                + {4'b0, TCP_DOFF, TCP_FLAGS} + {4'b0, TCP_WINDOW}
                + {4'b0, hdr_reg.src[31:16]} + {4'b0, hdr_reg.src[15:0]}
                + {4'b0, hdr_reg.dst[31:16]} + {4'b0, hdr_reg.dst[15:0]}
                + {12'b0, IP_PROTO} + {4'b0, tcp_len};
        tcp_csum = ~fold_sum(tcp_acc);
    end

    always_comb begin
        case (idx_reg)
            W_VER_LEN:   word = {IP_VER_IHL, 8'h00, tot_len};
            W_IDENT:     word = {hdr_reg.ident, 16'h0000};
            W_TTL_CSUM:  word = {IP_TTL, IP_PROTO, ip_csum};
            W_SRC_ADDR:  word = hdr_reg.src;
            W_DST_ADDR:  word = hdr_reg.dst;
            W_PORTS:     word = {hdr_reg.sport, hdr_reg.dport};
            W_SEQ:       word = hdr_reg.seq;
            W_ACK:       word = hdr_reg.ack;
            W_FLAGS_WIN: word = {TCP_DOFF, TCP_FLAGS, TCP_WINDOW};
            W_CSUM_URG:  word = {tcp_csum, 16'h0000};
            default:     word = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (snap_valid && snap_ready) begin
            hdr_reg <= snap;
        end
        if (pop) begin
            m_data_reg.header_word <= word;
            m_data_reg.word_index  <= idx_reg;
            m_data_reg.last_word   <= last;
            m_data_reg.oversize    <= hdr_reg.too_long;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_valid_reg <= 1'b0;
            idx_reg       <= W_VER_LEN;
            m_valid_reg   <= 1'b0;
        end else begin
            if (snap_valid && snap_ready) begin
                hdr_valid_reg <= 1'b1;
                idx_reg       <= W_VER_LEN;
            end else if (pop && last) begin
                hdr_valid_reg <= 1'b0;
            end else if (pop) begin
                idx_reg <= idx_reg + 4'd1;
            end

            if (pop) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: bench/tcp_ipv4_header_synth_test.sv
module tcp_ipv4_header_synth_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tcphs_pkg::*;

    localparam logic [16:0] PAYLOAD_LIMIT = 17'd65495;
    localparam int PARK_CYCLES = 120;
    localparam int SETTLE_CYCLES = 8;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    in_beat_t              s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_beat_t             m_data;

    tcp_ipv4_header_synth dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // register shadows
    logic [31:0] cfg_client_ip = '0;
    logic [31:0] cfg_target_ip = '0;
    logic [15:0] cfg_client_port = '0;
    logic [15:0] cfg_target_port = '0;

    // segment and connection state
    logic [15:0] pay_sum = '0;
    logic [16:0] pay_count = '0;
    logic        pay_oversize = 1'b0;
    logic [31:0] client_seq = '0;
    logic [31:0] target_seq = '1;
    logic [15:0] ip_id = '0;

    out_beat_t hdr_expected[$];
    out_beat_t want;

    int unsigned beats_sent = 0;
    int unsigned segments_closed = 0;
    int unsigned oversize_segments = 0;
    int unsigned words_checked = 0;
    int unsigned mismatches = 0;
    int unsigned send_gap_odds = 6;
    bit          quiet_mode = 1'b0;
    bit          hold_request = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #(20_000_000);
        $display("timeout with %0d header words outstanding", hdr_expected.size());
        $display("[tcp_ipv4_header_synth] ERROR");
        $finish;
    end

    function automatic logic [15:0] fold_ones(input logic [31:0] s);
        logic [31:0] t;
        t = {16'h0, s[15:0]} + {16'h0, s[31:16]};
        t = {16'h0, t[15:0]} + {16'h0, t[31:16]};
        return t[15:0];
    endfunction

    function automatic logic [31:0] add_halves(input logic [31:0] acc, input logic [31:0] w);
        return acc + {16'h0, w[31:16]} + {16'h0, w[15:0]};
    endfunction

    // Fold one accepted beat into the segment; on an end beat queue the ten header words.
    function automatic void account_beat(input in_beat_t b);
        logic [31:0] words [10];
        logic [31:0] src, dst, seq_no, ack_no, acc;
        logic [15:0] sport, dport, ip_len, tcp_len;
        out_beat_t o;
        if (b.byte_valid) begin
            if (pay_count == PAYLOAD_LIMIT) pay_oversize = 1'b1;
            // even offsets land in the high byte of the 16-bit word
            acc = pay_count[0] ? {24'h0, b.payload_byte} : {16'h0, b.payload_byte, 8'h0};
            pay_sum = fold_ones(acc + {16'h0, pay_sum});
            pay_count = pay_count + 17'd1;
        end
        if (!b.end_of_segment) return;
        if (b.from_target) begin
            src = cfg_target_ip;
            dst = cfg_client_ip;
            sport = cfg_target_port;
            dport = cfg_client_port;
            seq_no = target_seq;
            ack_no = client_seq;
        end else begin
            src = cfg_client_ip;
            dst = cfg_target_ip;
            sport = cfg_client_port;
            dport = cfg_target_port;
            seq_no = client_seq;
            ack_no = target_seq;
        end
        ip_len = pay_count[15:0] + 16'd40;
        tcp_len = pay_count[15:0] + 16'd20;
        words[0] = {8'h45, 8'h00, ip_len};
        words[1] = {ip_id, 16'h0000};
        words[2] = {8'd64, 8'd6, 16'h0000};
        words[3] = src;
        words[4] = dst;
        words[5] = {sport, dport};
        words[6] = seq_no;
        words[7] = ack_no;
        words[8] = {4'd5, 12'h010, 16'hffff};
        words[9] = '0;
        acc = '0;
        for (int k = 0; k < 5; k++) acc = add_halves(acc, words[k]);
        words[2][15:0] = ~fold_ones(acc);
        // pseudo-header: addresses, protocol and TCP length
        acc = {16'h0, pay_sum};
        for (int k = 5; k < 9; k++) acc = add_halves(acc, words[k]);
        acc = add_halves(acc, src);
        acc = add_halves(acc, dst);
        acc = acc + 32'd6 + {16'h0, tcp_len};
        words[9][31:16] = ~fold_ones(acc);
        for (int k = 0; k < 10; k++) begin
            o.header_word = words[k];
            o.word_index = 4'(k);
            o.last_word = (k == 9);
            o.oversize = pay_oversize;
            hdr_expected.push_back(o);
        end
        if (b.from_target) target_seq = target_seq + {15'h0, pay_count};
        else client_seq = client_seq + {15'h0, pay_count};
        ip_id = ip_id + 16'd1;
        segments_closed++;
        if (pay_oversize) oversize_segments++;
        pay_sum = '0;
        pay_count = '0;
        pay_oversize = 1'b0;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_CLIENT_ADDR: cfg_client_ip = val;
            CFG_TARGET_ADDR: cfg_target_ip = val;
            CFG_CLIENT_PORT: cfg_client_port = val[15:0];
            CFG_TARGET_PORT: cfg_target_port = val[15:0];
            CFG_INITIAL_SEQ: begin
                client_seq = val;
                target_seq = ~val;
            end
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic send_beat(input in_beat_t b);
        if (!quiet_mode && send_gap_odds != 0 && $urandom_range(1, send_gap_odds) == 1) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= b;
        do @(posedge aclk); while (!s_ready);
        account_beat(b);
        if (b.byte_valid || b.end_of_segment) beats_sent++;
    endtask

    task automatic send_segment(input int unsigned len, input logic side,
                                input bit end_on_byte, input bit noisy);
        in_beat_t b;
        for (int unsigned i = 0; i < len; i++) begin
            if (noisy && $urandom_range(0, 4) == 0) begin
                b.payload_byte = 8'($urandom);
                b.byte_valid = 1'b0;
                b.end_of_segment = 1'b0;
                b.from_target = 1'($urandom);
                send_beat(b);
            end
            b.payload_byte = 8'($urandom);
            b.byte_valid = 1'b1;
            b.end_of_segment = end_on_byte && (i == len - 1);
            b.from_target = b.end_of_segment ? side : 1'($urandom);
            send_beat(b);
        end
        if (!end_on_byte || len == 0) begin
            b.payload_byte = 8'($urandom);
            b.byte_valid = 1'b0;
            b.end_of_segment = 1'b1;
            b.from_target = side;
            send_beat(b);
        end
    endtask

    task automatic send_bytes(input logic [7:0] data, input logic vld, input logic eos,
                              input logic side);
        in_beat_t b;
        b.payload_byte = data;
        b.byte_valid = vld;
        b.end_of_segment = eos;
        b.from_target = side;
        send_beat(b);
    endtask

    // Hold the sender until every header word is out, then let the pipe go quiet.
    task automatic drain_headers();
        s_valid <= 1'b0;
        while (hdr_expected.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic check_field(input string what, input logic [31:0] exp_val,
                               input logic [31:0] got_val);
        if (got_val !== exp_val) begin
            mismatches++;
            if (mismatches <= 40)
                $display("%0t: %s expected %h actual %h", $time, what, exp_val, got_val);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (hdr_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 40)
                    $display("%0t: header word expected none actual %h index %0d", $time,
                             m_data.header_word, m_data.word_index);
            end else begin
                want = hdr_expected.pop_front();
                check_field("header_word", want.header_word, m_data.header_word);
                check_field("word_index", 32'(want.word_index), 32'(m_data.word_index));
                check_field("last_word", 32'(want.last_word), 32'(m_data.last_word));
                check_field("oversize", 32'(want.oversize), 32'(m_data.oversize));
                words_checked++;
            end
        end
    end

    initial begin : sink_pacing
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_request) begin
                m_ready <= 1'b0;
                repeat (PARK_CYCLES) @(posedge aclk);
                hold_request = 1'b0;
            end else if (!quiet_mode && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    task automatic test_reset_values();
        send_segment(0, 1'b0, 1'b0, 1'b0);
        send_segment(0, 1'b1, 1'b0, 1'b0);
        drain_headers();
    endtask

    task automatic test_register_extremes();
        write_reg(CFG_CLIENT_ADDR, '1);
        write_reg(CFG_TARGET_ADDR, '1);
        write_reg(CFG_CLIENT_PORT, '1);
        write_reg(CFG_TARGET_PORT, '1);
        write_reg(CFG_INITIAL_SEQ, '1);
        send_segment(2, 1'b0, 1'b1, 1'b0);
        send_segment(1, 1'b1, 1'b1, 1'b0);
        drain_headers();
        write_reg(CFG_CLIENT_ADDR, '0);
        write_reg(CFG_TARGET_ADDR, '0);
        write_reg(CFG_CLIENT_PORT, 32'hffff_0000);
        write_reg(CFG_TARGET_PORT, 32'h5a5a_0000);
        write_reg(CFG_INITIAL_SEQ, '0);
        // unmapped indexes must leave every register alone
        for (int i = int'(CFG_INITIAL_SEQ) + 1; i < (1 << CFG_IDX_W); i++)
            write_reg(CFG_IDX_W'(i), $urandom);
        send_segment(1, 1'b1, 1'b0, 1'b0);
        drain_headers();
        write_reg(CFG_CLIENT_ADDR, 32'hc0a8_0001);
        write_reg(CFG_TARGET_ADDR, 32'h0a00_00fe);
        write_reg(CFG_CLIENT_PORT, 32'd51022);
        write_reg(CFG_TARGET_PORT, 32'd22);
        write_reg(CFG_INITIAL_SEQ, $urandom);
    endtask

    task automatic test_directed_cases();
        send_bytes(8'ha5, 1'b0, 1'b0, 1'b1);
        send_bytes(8'h00, 1'b0, 1'b1, 1'b0);
        send_bytes(8'hff, 1'b1, 1'b0, 1'b0);
        send_bytes(8'hff, 1'b1, 1'b0, 1'b0);
        send_bytes(8'h3c, 1'b0, 1'b1, 1'b1);
        send_bytes(8'h00, 1'b1, 1'b0, 1'b1);
        send_bytes(8'h80, 1'b1, 1'b0, 1'b1);
        send_bytes(8'h01, 1'b1, 1'b1, 1'b0);
        send_bytes(8'h12, 1'b1, 1'b0, 1'b0);
        send_bytes(8'h5a, 1'b0, 1'b0, 1'b1);
        send_bytes(8'hfe, 1'b1, 1'b0, 1'b0);
        send_bytes(8'hff, 1'b1, 1'b1, 1'b1);
        send_bytes(8'hff, 1'b1, 1'b1, 1'b0);
        drain_headers();
    endtask

    task automatic test_receiver_stall();
        hold_request = 1'b1;
        for (int i = 0; i < 6; i++) send_segment(3, 1'(i), 1'b1, 1'b0);
        drain_headers();
    endtask

    task automatic test_random_traffic();
        int unsigned first;
        int unsigned len;
        logic [31:0] val;
        for (int phase = 0; phase < 5; phase++) begin
            drain_headers();
            for (int r = int'(CFG_CLIENT_ADDR); r <= int'(CFG_INITIAL_SEQ); r++) begin
                if ($urandom_range(0, 1) == 0) begin
                    case ($urandom_range(0, 3))
                        0: val = '0;
                        1: val = '1;
                        default: val = $urandom;
                    endcase
                    write_reg(CFG_IDX_W'(r), val);
                end
            end
            case (phase % 3)
                0: send_gap_odds = 0;
                1: send_gap_odds = 3;
                default: send_gap_odds = 8;
            endcase
            quiet_mode = (phase == 4);
            first = beats_sent;
            while (beats_sent - first < 32) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 48) : $urandom_range(0, 8);
                send_segment(len, 1'($urandom), 1'($urandom), $urandom_range(0, 3) == 0);
            end
        end
        drain_headers();
    endtask

    initial begin : run_tests
        int unsigned n;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data <= '0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_values();
        test_register_extremes();
        test_directed_cases();
        test_receiver_stall();
        test_random_traffic();

        quiet_mode = 1'b1;
        s_valid <= 1'b0;
        for (n = 0; n < 5000 && hdr_expected.size() != 0; n++) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (hdr_expected.size() != 0) begin
            mismatches++;
            $display("%0t: %0d header words expected but never seen", $time,
                     hdr_expected.size());
        end
        $display("closed %0d segments (%0d oversize) from %0d payload and end beats,",
                 segments_closed, oversize_segments, beats_sent);
        $display("compared %0d header words, %0d mismatches", words_checked, mismatches);
        if (mismatches == 0) begin
            $display("[tcp_ipv4_header_synth] OK");
        end else begin
            $display("[tcp_ipv4_header_synth] ERROR");
        end
        $finish;
    end

endmodule
